// ===== hw/rtl/itc_pkg.sv =====
// Shared types and constants for the image template convolution block.
// Used by itc_linebuf, itc_mac and image_template_convolution_top.
package itc_pkg;

  localparam int MAX_WIDTH  = 1024;  // pixels per row held in each line bank
  localparam int MAX_KERNEL = 5;     // kernel rows and columns
  localparam int KSLOTS     = MAX_KERNEL * MAX_KERNEL;
  localparam int MAX_ROWS   = 4096;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int IW_W      = 11;
  localparam int IH_W      = 13;
  localparam int KDIM_W    = 3;
  localparam int HALF_W    = $clog2(MAX_KERNEL / 2 + 1);
  localparam int SLOT_W    = $clog2(MAX_KERNEL);
  localparam int CIDX_W    = 5;
  localparam int PIX_W     = 16;
  localparam int PROD_W    = 2 * PIX_W;
  localparam int ROWSUM_W  = PROD_W + $clog2(MAX_KERNEL);
  localparam int FILT_W    = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 64;

  localparam logic [IW_W-1:0]   RST_IMAGE_WIDTH   = IW_W'(640);
  localparam logic [IH_W-1:0]   RST_IMAGE_HEIGHT  = IH_W'(480);
  localparam logic [KDIM_W-1:0] RST_KERNEL_WIDTH  = KDIM_W'(3);
  localparam logic [KDIM_W-1:0] RST_KERNEL_HEIGHT = KDIM_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_KERNEL_WIDTH,
    REG_KERNEL_HEIGHT
  } itc_reg_t;

  typedef enum logic {
    CMD_COEF  = 1'b0,
    CMD_PIXEL = 1'b1
  } itc_cmd_t;

  typedef logic signed [PIX_W-1:0] itc_sample_t;

  // effective kernel geometry after clamping
  typedef struct packed {
    logic [KDIM_W-1:0] kw;
    logic [KDIM_W-1:0] kh;
    logic [HALF_W-1:0] hw;
    logic [HALF_W-1:0] hh;
  } itc_geom_t;

  // load enables of the multiply-accumulate stages, and the interior flag
  typedef struct packed {
    logic prod_en;
    logic row_en;
    logic sum_en;
    logic interior;
  } itc_mac_ctl_t;

  // position carried along with an item
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             interior;
    logic             last;
  } itc_pos_t;

endpackage

// ===== hw/rtl/itc_linebuf.sv =====
// Line buffer: one RAM bank per kernel row, holding the most recent image rows.
// Depends on itc_pkg. Read data is registered and held between pixel items.
module itc_linebuf (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [itc_pkg::SLOT_W-1:0]          wr_slot,
  input  logic [itc_pkg::COL_W-1:0]           col,
  input  itc_pkg::itc_sample_t                wr_data,
  output itc_pkg::itc_sample_t                rd_data [itc_pkg::MAX_KERNEL]
);

  for (genvar b = 0; b < itc_pkg::MAX_KERNEL; b++) begin : g_bank
    itc_pkg::itc_sample_t mem [itc_pkg::MAX_WIDTH];

    // every bank is read at each pixel; the bank being written returns its old data
    always_ff @(posedge clk) begin
      if (wr_en && (wr_slot == itc_pkg::SLOT_W'(b))) begin
        mem[col] <= wr_data;
      end
      if (wr_en) begin
        rd_data[b] <= mem[col];
      end
    end
  end

endmodule

// ===== hw/rtl/itc_mac.sv =====
// Multiply-accumulate datapath: 25 products, per-row sums, final sum.
// Depends on itc_pkg. Three register stages, each loaded by its own enable.
module itc_mac (
  input  logic                                clk,
  input  itc_pkg::itc_mac_ctl_t               ctl,
  input  itc_pkg::itc_geom_t                  geom,
  input  itc_pkg::itc_sample_t                win  [itc_pkg::MAX_KERNEL][itc_pkg::MAX_KERNEL],
  input  itc_pkg::itc_sample_t                kern [itc_pkg::MAX_KERNEL][itc_pkg::MAX_KERNEL],
  output logic signed [itc_pkg::FILT_W-1:0]   filtered
);

  localparam int K = itc_pkg::MAX_KERNEL;

  logic                                  sel_ok    [K][K];
  logic [itc_pkg::SLOT_W-1:0]            age       [K][K];
  logic [itc_pkg::SLOT_W-1:0]            dcol      [K][K];
  itc_pkg::itc_sample_t                  win_sel   [K][K];
  logic signed [itc_pkg::PROD_W-1:0]     prod_next [K][K];
  logic signed [itc_pkg::PROD_W-1:0]     prod      [K][K];
  logic signed [itc_pkg::ROWSUM_W-1:0]   rs_next   [K];
  logic signed [itc_pkg::ROWSUM_W-1:0]   row_sum   [K];
  logic signed [itc_pkg::FILT_W-1:0]     filtered_next;

  // coefficient (m,n) meets the pixel 2*hh-m rows and 2*hw-n columns back
  always_comb begin
    for (int m = 0; m < K; m++) begin
      for (int n = 0; n < K; n++) begin
        sel_ok[m][n] = ctl.interior && (itc_pkg::KDIM_W'(m) < geom.kh) &&
                       (itc_pkg::KDIM_W'(n) < geom.kw);
        if (sel_ok[m][n]) begin
          age[m][n]  = itc_pkg::SLOT_W'({geom.hh, 1'b0}) - itc_pkg::SLOT_W'(m);
          dcol[m][n] = itc_pkg::SLOT_W'({geom.hw, 1'b0}) - itc_pkg::SLOT_W'(n);
        end else begin
          age[m][n]  = '0;
          dcol[m][n] = '0;
        end
        win_sel[m][n] = win[age[m][n]][dcol[m][n]];
        if (sel_ok[m][n]) begin
          prod_next[m][n] = win_sel[m][n] * kern[m][n];
        end else begin
          prod_next[m][n] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int m = 0; m < K; m++) begin
      rs_next[m] = '0;
      for (int n = 0; n < K; n++) begin
        rs_next[m] = rs_next[m] + itc_pkg::ROWSUM_W'(prod[m][n]);
      end
    end
    filtered_next = '0;
    for (int m = 0; m < K; m++) begin
      filtered_next = filtered_next + itc_pkg::FILT_W'(row_sum[m]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod <= prod_next;
    end
    if (ctl.row_en) begin
      row_sum <= rs_next;
    end
    if (ctl.sum_en) begin
      filtered <= filtered_next;
    end
  end

endmodule

// ===== hw/rtl/image_template_convolution_top.sv =====
// Top level of the image template convolution block.
// Depends on itc_pkg, itc_linebuf and itc_mac.
//
// Input stream s_t*: tuser selects the item kind (coefficient load or pixel);
// tdata carries coef_index, coefficient and pixel. Pixels arrive in raster
// order. Each pixel yields at most one result on m_t*, for the position half
// a kernel up and to the left; tlast marks the frame's final pixel. Positions
// less than half a kernel from the top or left edge give zero, those near the
// bottom or right edge give none. Coefficient loads give no result and take
// effect for pixels that follow them in the stream. One item is accepted per
// clock while s_tready is high. A pixel's result passes one register stage
// each for line RAM read, window shift, products, row sums and final sum.
// Five line banks of MAX_WIDTH x 16 bits hold the most recent rows; each is
// read once per pixel. Every stage has its own valid, so bubbles close up and
// items keep entering while a result waits in the output register; once all
// stages are full a stalled m_tready holds s_tready low.
// Reset (rst, synchronous) restores the geometry registers, the frame
// position and empties the pipeline; line and kernel stores keep their data.
// A write on cfg_* restarts the frame at row 0, column 0.
module image_template_convolution_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [4:0] coef_index, [20:5] coefficient, [36:21] pixel, [39:37] zero
  input  logic [itc_pkg::S_TDATA_W-1:0]        s_tdata,
  // [0] command
  input  logic [0:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [11:0] out_row, [21:12] out_col, [61:22] filtered, [63:62] zero
  output logic [itc_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic                                 m_tlast,
  input  logic                                 cfg_we,
  input  logic [itc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [itc_pkg::CFG_W-1:0]            cfg_data
);

  localparam int K = itc_pkg::MAX_KERNEL;

  // geometry registers
  logic [itc_pkg::IW_W-1:0]   image_width;
  logic [itc_pkg::IH_W-1:0]   image_height;
  logic [itc_pkg::KDIM_W-1:0] kernel_width;
  logic [itc_pkg::KDIM_W-1:0] kernel_height;

  logic [itc_pkg::IW_W-1:0]   w_eff;
  logic [itc_pkg::IH_W-1:0]   h_eff;
  itc_pkg::itc_geom_t         geom;

  // frame position
  logic [itc_pkg::COL_W-1:0]  col_count;
  logic [itc_pkg::ROW_W-1:0]  row_count;
  logic [itc_pkg::SLOT_W-1:0] row_slot;

  // input decode
  itc_pkg::itc_cmd_t          in_cmd;
  logic [itc_pkg::CIDX_W-1:0] in_cidx;
  itc_pkg::itc_sample_t       in_coef;
  itc_pkg::itc_sample_t       in_pixel;
  logic                       acc;
  logic                       acc_pix;
  logic                       col_end;
  logic                       row_end;
  logic                       emit_now;
  itc_pkg::itc_pos_t          pos_now;

  // pipeline
  logic                       v1, v2, v3, v4, v5;
  logic                       rdy1, rdy2, rdy3, rdy4, rdy5;
  itc_pkg::itc_cmd_t          s1_cmd;
  logic [itc_pkg::CIDX_W-1:0] s1_cidx;
  itc_pkg::itc_sample_t       s1_coef;
  itc_pkg::itc_sample_t       s1_pixel;
  logic                       s1_emit;
  logic [itc_pkg::SLOT_W-1:0] s1_slot;
  itc_pkg::itc_pos_t          pos1, pos2, pos3, pos4, pos5;
  logic                       go1;

  itc_pkg::itc_sample_t       rd_data [K];
  logic [itc_pkg::SLOT_W-1:0] bank_of [K];
  itc_pkg::itc_sample_t       col_new [K];
  itc_pkg::itc_sample_t       win     [K][K];
  itc_pkg::itc_sample_t       kern    [K][K];
  itc_pkg::itc_mac_ctl_t      mac_ctl;
  logic signed [itc_pkg::FILT_W-1:0] filtered;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= itc_pkg::RST_IMAGE_WIDTH;
      image_height  <= itc_pkg::RST_IMAGE_HEIGHT;
      kernel_width  <= itc_pkg::RST_KERNEL_WIDTH;
      kernel_height <= itc_pkg::RST_KERNEL_HEIGHT;
    end else if (cfg_we) begin
      case (itc_pkg::itc_reg_t'(cfg_index))
        itc_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[itc_pkg::IW_W-1:0];
        itc_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[itc_pkg::IH_W-1:0];
        itc_pkg::REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[itc_pkg::KDIM_W-1:0];
        itc_pkg::REG_KERNEL_HEIGHT: kernel_height <= cfg_data[itc_pkg::KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize values clamp to the maximum
  always_comb begin
    if (image_width == '0) begin
      w_eff = itc_pkg::IW_W'(1);
    end else if (image_width > itc_pkg::IW_W'(itc_pkg::MAX_WIDTH)) begin
      w_eff = itc_pkg::IW_W'(itc_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = itc_pkg::IH_W'(1);
    end else if (image_height > itc_pkg::IH_W'(itc_pkg::MAX_ROWS)) begin
      h_eff = itc_pkg::IH_W'(itc_pkg::MAX_ROWS);
    end else begin
      h_eff = image_height;
    end
    if (kernel_width == '0) begin
      geom.kw = itc_pkg::KDIM_W'(1);
    end else if (kernel_width > itc_pkg::KDIM_W'(K)) begin
      geom.kw = itc_pkg::KDIM_W'(K);
    end else begin
      geom.kw = kernel_width;
    end
    if (kernel_height == '0) begin
      geom.kh = itc_pkg::KDIM_W'(1);
    end else if (kernel_height > itc_pkg::KDIM_W'(K)) begin
      geom.kh = itc_pkg::KDIM_W'(K);
    end else begin
      geom.kh = kernel_height;
    end
    geom.hw = itc_pkg::HALF_W'(geom.kw >> 1);
    geom.hh = itc_pkg::HALF_W'(geom.kh >> 1);
  end

  // ----------------------------------------------------------- input side
  assign in_cmd   = itc_pkg::itc_cmd_t'(s_tuser[0]);
  assign in_cidx  = s_tdata[4:0];
  assign in_coef  = s_tdata[20:5];
  assign in_pixel = s_tdata[36:21];

  assign acc     = s_tvalid && s_tready;
  assign acc_pix = acc && (in_cmd == itc_pkg::CMD_PIXEL);

  assign col_end = ({1'b0, col_count} == (w_eff - itc_pkg::IW_W'(1)));
  assign row_end = ({1'b0, row_count} == (h_eff - itc_pkg::IH_W'(1)));

  // the window ends at the current pixel, so the far edges are always inside
  always_comb begin
    emit_now = (row_count >= itc_pkg::ROW_W'(geom.hh)) &&
               (col_count >= itc_pkg::COL_W'(geom.hw));
    pos_now.row      = row_count - itc_pkg::ROW_W'(geom.hh);
    pos_now.col      = col_count - itc_pkg::COL_W'(geom.hw);
    pos_now.interior = emit_now &&
                       (row_count >= itc_pkg::ROW_W'({geom.hh, 1'b0})) &&
                       (col_count >= itc_pkg::COL_W'({geom.hw, 1'b0}));
    pos_now.last     = row_end && col_end;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col_count <= '0;
      row_count <= '0;
      row_slot  <= '0;
    end else if (acc_pix) begin
      if (col_end) begin
        col_count <= '0;
        if (row_end) begin
          row_count <= '0;
          row_slot  <= '0;
        end else begin
          row_count <= row_count + itc_pkg::ROW_W'(1);
          if (row_slot == itc_pkg::SLOT_W'(K - 1)) begin
            row_slot <= '0;
          end else begin
            row_slot <= row_slot + itc_pkg::SLOT_W'(1);
          end
        end
      end else begin
        col_count <= col_count + itc_pkg::COL_W'(1);
      end
    end
  end

  // ------------------------------------------------------------- handshake
  assign rdy5     = !v5 || m_tready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign go1      = v1 && rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1 && (s1_cmd == itc_pkg::CMD_PIXEL) && s1_emit;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd   <= in_cmd;
      s1_cidx  <= in_cidx;
      s1_coef  <= in_coef;
      s1_pixel <= in_pixel;
      s1_emit  <= emit_now;
      s1_slot  <= row_slot;
      pos1     <= pos_now;
    end
    if (rdy2) pos2 <= pos1;
    if (rdy3) pos3 <= pos2;
    if (rdy4) pos4 <= pos3;
    if (rdy5) pos5 <= pos4;
  end

  // ----------------------------------------------------------- line banks
  itc_linebuf u_linebuf (
    .clk     (clk),
    .wr_en   (acc_pix),
    .wr_slot (row_slot),
    .col     (col_count),
    .wr_data (in_pixel),
    .rd_data (rd_data)
  );

  // age k (rows back from the current one) lives in bank (slot - k) mod K
  always_comb begin
    for (int k = 0; k < K; k++) begin
      if (s1_slot >= itc_pkg::SLOT_W'(k)) begin
        bank_of[k] = s1_slot - itc_pkg::SLOT_W'(k);
      end else begin
        bank_of[k] = s1_slot + itc_pkg::SLOT_W'(K - k);
      end
      if (k == 0) begin
        col_new[k] = s1_pixel;
      end else begin
        col_new[k] = rd_data[bank_of[k]];
      end
    end
  end

  // window and kernel change as an item leaves stage 1, so the item in
  // stage 2 always sees exactly the state it would have in stream order
  always_ff @(posedge clk) begin
    if (go1 && (s1_cmd == itc_pkg::CMD_PIXEL)) begin
      for (int k = 0; k < K; k++) begin
        for (int d = 0; d < K; d++) begin
          if (d == 0) begin
            win[k][d] <= col_new[k];
          end else begin
            win[k][d] <= win[k][d-1];
          end
        end
      end
    end
    if (go1 && (s1_cmd == itc_pkg::CMD_COEF)) begin
      for (int m = 0; m < K; m++) begin
        for (int n = 0; n < K; n++) begin
          if (s1_cidx == itc_pkg::CIDX_W'(m * K + n)) begin
            kern[m][n] <= s1_coef;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------- datapath
  always_comb begin
    mac_ctl.prod_en  = v2 && rdy3;
    mac_ctl.row_en   = v3 && rdy4;
    mac_ctl.sum_en   = v4 && rdy5;
    mac_ctl.interior = pos2.interior;
  end

  itc_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .geom     (geom),
    .win      (win),
    .kern     (kern),
    .filtered (filtered)
  );

  assign m_tvalid = v5;
  assign m_tlast  = pos5.last;
  assign m_tdata  = {2'b00, filtered, pos5.col, pos5.row};

  // ------------------------------------------------------------- checks
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col_count} < w_eff) && ({1'b0, row_count} < h_eff))
    else $error("frame position outside the configured image");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    row_slot < itc_pkg::SLOT_W'(K))
    else $error("line bank slot out of range");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (col_count == '0) && (row_count == '0) && (row_slot == '0))
    else $error("register write did not restart the frame");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (v1 && rdy2 && (s1_cmd == itc_pkg::CMD_COEF)) |=> !v2)
    else $error("coefficient load entered the result pipeline");

  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    (v5 && !pos5.interior) |-> (filtered == '0))
    else $error("border position produced a nonzero sum");

endmodule
